### hw/rtl/fhq_pkg.sv
// Shared constants, types and the distributed-arithmetic table for the FIR
// Hilbert quadrature splitter. No dependencies.
`default_nettype none

package fhq_pkg;

	localparam int TAP_COUNT   = 31;
	localparam int SAMPLE_BITS = 24;
	localparam int COEF_BITS   = 18;
	localparam int HALF_DELAY  = (TAP_COUNT - 1) / 2;
	localparam int FRAC_SHIFT  = COEF_BITS - 1;

	// Antisymmetric filter: h[30-i] = -h[i], only even i carry weight.
	// Pair p combines taps 2+2p and 28-2p.
	localparam int PAIR_COUNT = 7;
	localparam int PAIR_FIRST = 2;
	localparam int DIFF_BITS  = SAMPLE_BITS + 1;
	localparam int DA_BITS    = COEF_BITS;
	localparam int DA_DEPTH   = 1 << PAIR_COUNT;
	localparam int ACC_BITS   = DIFF_BITS + DA_BITS;
	localparam int Q_BITS     = ACC_BITS - FRAC_SHIFT;
	localparam int CNT_BITS   = $clog2(DIFF_BITS);
	localparam int TDATA_IN_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int TDATA_OUT_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8;

	localparam int PAIR_COEF [PAIR_COUNT] = '{-108, -585, -1861, -4697, -10514, -23621,
		-81954};

	typedef logic signed [DA_BITS-1:0] da_word_t;
	typedef da_word_t da_rom_t [DA_DEPTH];
	typedef logic [PAIR_COUNT-1:0][DIFF_BITS-1:0] diff_vec_t;

	typedef struct packed {
		logic load;
		logic step;
		logic first;
	} mac_ctrl_t;

	// Entry a holds the sum of the pair coefficients selected by the bits of a.
	function automatic da_rom_t build_da_rom();
		da_rom_t rom;
		int      s;
		for (int a = 0; a < DA_DEPTH; a++) begin
			s = 0;
			for (int p = 0; p < PAIR_COUNT; p++) begin
				if (((a >> p) & 1) != 0) begin
					s = s + PAIR_COEF[p];
				end
			end
			rom[a] = DA_BITS'(s);
		end
		return rom;
	endfunction

	localparam da_rom_t DA_ROM = build_da_rom();

endpackage

`default_nettype wire

### hw/rtl/fhq_delay_line.sv
// Sample history as a 31-stage shift line plus the pair differences of the
// antisymmetric taps. Depends on fhq_pkg.
`default_nettype none

module fhq_delay_line (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                shift_en,
	input  wire logic signed [fhq_pkg::SAMPLE_BITS-1:0] sample_in,
	output logic signed [fhq_pkg::SAMPLE_BITS-1:0]      tap_mid,
	output fhq_pkg::diff_vec_t                       pair_diff
);
	import fhq_pkg::*;

	logic signed [SAMPLE_BITS-1:0] hist_q [TAP_COUNT];

	// Advance the line by one sample; stage 0 holds the newest.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAP_COUNT; k++) begin
				hist_q[k] <= '0;
			end
		end else if (shift_en) begin
			hist_q[0] <= sample_in;
			for (int k = 1; k < TAP_COUNT; k++) begin
				hist_q[k] <= hist_q[k-1];
			end
		end
	end

	assign tap_mid = hist_q[HALF_DELAY];

	for (genvar p = 0; p < PAIR_COUNT; p++) begin : g_pair
		localparam int LO = PAIR_FIRST + 2 * p;
		localparam int HI = TAP_COUNT - 1 - LO;
		assign pair_diff[p] = {hist_q[LO][SAMPLE_BITS-1], hist_q[LO]}
			- {hist_q[HI][SAMPLE_BITS-1], hist_q[HI]};
	end

endmodule

`default_nettype wire

### hw/rtl/fhq_da_mac.sv
// Bit-serial distributed-arithmetic accumulator: one bit of every pair
// difference per cycle, MSB first, then round and saturate. Depends on fhq_pkg.
`default_nettype none

module fhq_da_mac (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  fhq_pkg::mac_ctrl_t                       ctrl,
	input  fhq_pkg::diff_vec_t                       pair_diff,
	output logic signed [fhq_pkg::SAMPLE_BITS-1:0]      quad
);
	import fhq_pkg::*;

	diff_vec_t                   diff_q;
	logic signed [ACC_BITS-1:0]  acc_q;
	logic [PAIR_COUNT-1:0]       addr;
	logic signed [ACC_BITS-1:0]  term;
	logic signed [ACC_BITS-1:0]  rsum;
	logic signed [Q_BITS-1:0]    qv;
	logic                        ovf;

	always_comb begin
		for (int p = 0; p < PAIR_COUNT; p++) begin
			addr[p] = diff_q[p][DIFF_BITS-1];
		end
	end

	assign term = ACC_BITS'(DA_ROM[addr]);

	// Load the differences, then shift them out MSB first; the sign bit
	// carries negative weight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.load) begin
			acc_q <= '0;
		end else if (ctrl.step) begin
			acc_q <= {acc_q[ACC_BITS-2:0], 1'b0} + (ctrl.first ? -term : term);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			diff_q <= pair_diff;
		end else if (ctrl.step) begin
			for (int p = 0; p < PAIR_COUNT; p++) begin
				diff_q[p] <= {diff_q[p][DIFF_BITS-2:0], 1'b0};
			end
		end
	end

	// Round half up, then clamp to the sample range.
	assign rsum = acc_q + (ACC_BITS'(1) <<< (FRAC_SHIFT - 1));
	assign qv   = rsum[ACC_BITS-1:FRAC_SHIFT];
	assign ovf  = !((qv[Q_BITS-1:SAMPLE_BITS-1] == '0) || (qv[Q_BITS-1:SAMPLE_BITS-1] == '1));

	always_comb begin
		if (ovf) begin
			quad = qv[Q_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
				: {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end else begin
			quad = qv[SAMPLE_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/fir_hilbert_quadrature_splitter_top.sv
// Top level of the 31-tap FIR Hilbert quadrature splitter: stream ports,
// sequencer and output register. Depends on fhq_pkg, fhq_delay_line, fhq_da_mac.
//
// Usage:
//   Input channel s_*: one beat carries one 24-bit Q1.23 audio sample.
//   Output channel m_*: one beat per input beat, carrying in_phase (the
//   sample from fifteen beats earlier) and quadrature (the Hilbert-filtered
//   sample, rounded half up and saturated to 24 bits).
//   The bit-serial accumulator spends one cycle per bit of the 25-bit pair
//   differences; the sequencer loads the differences before the first bit,
//   delivers the rounded result after the last one and then returns to idle.
//   s_tready is high only while the sequencer is idle, so one sample is in
//   flight at a time. A finished result waits in the output register; the
//   next sample is still taken meanwhile. If the receiver stalls long enough
//   that a second result is ready, the sequencer holds in its final state
//   until the output register frees up.
//   Reset clears the sample history to zero (in_phase reads zero for the
//   first fifteen beats), empties the output register and idles the
//   sequencer.
`default_nettype none

module fir_hilbert_quadrature_splitter_top (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	input  wire logic [fhq_pkg::TDATA_IN_BITS-1:0]     s_tdata,  // [23:0] sample
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	output logic [fhq_pkg::TDATA_OUT_BITS-1:0]         m_tdata   // [23:0] in_phase,
	                                                             // [47:24] quadrature
);
	import fhq_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOAD = 4'b0010,
		ST_RUN  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t                         state_q;
	logic [CNT_BITS-1:0]            cnt_q;
	logic                           in_fire;
	logic                           out_write;
	mac_ctrl_t                      ctrl;
	diff_vec_t                      pair_diff;
	logic signed [SAMPLE_BITS-1:0]  tap_mid;
	logic signed [SAMPLE_BITS-1:0]  quad;
	logic signed [SAMPLE_BITS-1:0]  in_phase_q;
	logic signed [SAMPLE_BITS-1:0]  quadrature_q;
	logic                           out_valid_q;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	// Write the result only when the output register is empty or draining.
	assign out_write = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	assign ctrl.load  = (state_q == ST_LOAD);
	assign ctrl.step  = (state_q == ST_RUN);
	assign ctrl.first = (cnt_q == '0);

	fhq_delay_line u_line (
		.clk       (clk),
		.arst_n    (arst_n),
		.shift_en  (in_fire),
		.sample_in (s_tdata[SAMPLE_BITS-1:0]),
		.tap_mid   (tap_mid),
		.pair_diff (pair_diff)
	);

	fhq_da_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.pair_diff (pair_diff),
		.quad      (quad)
	);

	// Sequencer: idle -> load differences -> one step per bit -> deliver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					cnt_q   <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (cnt_q == CNT_BITS'(DIFF_BITS - 1)) begin
						state_q <= ST_DONE;
					end
					cnt_q <= cnt_q + CNT_BITS'(1);
				end
				ST_DONE: begin
					if (out_write) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: hold the beat until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_write) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_write) begin
			in_phase_q   <= tap_mid;
			quadrature_q <= quad;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = TDATA_OUT_BITS'({quadrature_q, in_phase_q});

endmodule

`default_nettype wire
